// ===== hw/rtl/pfa_pkg.sv =====
// shared types, constants and codes of the pooled fragment allocator
package pfa_pkg;

  localparam int unsigned NUM_FRAGS_DEF  = 4096;
  localparam int unsigned NUM_POOLS_DEF  = 16;
  localparam int unsigned FRAG_BYTES_DEF = 65536;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned POOL_W   = 4;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned OFF_W    = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_BUF  = 2'd0,
    MODE_STR  = 2'd1,
    MODE_FREE = 2'd2,
    MODE_NOP  = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_LEN    = 2'd1,
    STAT_NOFRAG = 2'd2
  } status_e;

  // how an accepted request is handled
  typedef enum logic [1:0] {
    KIND_RSV,
    KIND_FREE,
    KIND_DIRECT
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_WSTART,
    S_WALK,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POOL_W-1:0] pool_id;
    logic [LEN_W-1:0]  alloc_length;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    frag_index;
    logic [OFF_W-1:0]    byte_offset;
    logic [IDX_W-1:0]    frags_released;
  } rsp_t;

  typedef struct packed {
    logic accept;
    logic rsv_read;
    logic rsv_eval;
    logic walk_start;
    logic walk_step;
    logic fin_load;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  walk_ok;
    logic  walk_more;
    logic  out_free;
  } stat_t;

endpackage

// ===== hw/rtl/pfa_req_if.sv =====
// request channel of the allocator
interface pfa_req_if;
  logic          valid;
  logic          ready;
  pfa_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/pfa_rsp_if.sv =====
// result channel of the allocator
interface pfa_rsp_if;
  logic          valid;
  logic          ready;
  pfa_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/pfa_ctrl.sv =====
// sequencing state machine of the allocator
module pfa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  pfa_pkg::stat_t stat_i,
  output pfa_pkg::cmd_t  cmd_o
);

  pfa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pfa_pkg::S_IDLE: begin
        if (req_valid_i) begin
          case (stat_i.kind)
            pfa_pkg::KIND_RSV:  state_d = pfa_pkg::S_READ;
            pfa_pkg::KIND_FREE: state_d = pfa_pkg::S_WSTART;
            default:            state_d = pfa_pkg::S_FIN;
          endcase
        end
      end
      pfa_pkg::S_READ: state_d = pfa_pkg::S_EVAL;
      pfa_pkg::S_EVAL: begin
        if (stat_i.out_free) state_d = pfa_pkg::S_IDLE;
      end
      pfa_pkg::S_WSTART: begin
        state_d = stat_i.walk_ok ? pfa_pkg::S_WALK : pfa_pkg::S_FIN;
      end
      pfa_pkg::S_WALK: begin
        if (!stat_i.walk_more) state_d = pfa_pkg::S_FIN;
      end
      pfa_pkg::S_FIN: begin
        if (stat_i.out_free) state_d = pfa_pkg::S_IDLE;
      end
      default: state_d = pfa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      pfa_pkg::S_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.accept  = req_valid_i;
      end
      pfa_pkg::S_READ:   cmd_o.rsv_read   = 1'b1;
      pfa_pkg::S_EVAL:   cmd_o.rsv_eval   = stat_i.out_free;
      pfa_pkg::S_WSTART: cmd_o.walk_start = 1'b1;
      pfa_pkg::S_WALK:   cmd_o.walk_step  = 1'b1;
      pfa_pkg::S_FIN:    cmd_o.fin_load   = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/pfa_dp.sv =====
// allocator datapath: link and room tables, pool heads, free list and result register
module pfa_dp #(
  parameter int unsigned NUM_FRAGS  = pfa_pkg::NUM_FRAGS_DEF,
  parameter int unsigned NUM_POOLS  = pfa_pkg::NUM_POOLS_DEF,
  parameter int unsigned FRAG_BYTES = pfa_pkg::FRAG_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pfa_pkg::req_t  req_i,
  input  pfa_pkg::cmd_t  cmd_i,
  output pfa_pkg::stat_t stat_o,
  input  logic           rsp_ready_i,
  output logic           rsp_valid_o,
  output pfa_pkg::rsp_t  rsp_o
);

  localparam int unsigned FW = $clog2(NUM_FRAGS);
  localparam int unsigned CW = $clog2(NUM_FRAGS + 1);
  localparam int unsigned PW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int unsigned BW = $clog2(FRAG_BYTES);
  localparam int unsigned LW = ((BW > pfa_pkg::LEN_W) ? BW : pfa_pkg::LEN_W) + 1;
  localparam int unsigned NUM_IDS = 2 ** pfa_pkg::POOL_W;
  localparam logic [BW-1:0] CAP_B = BW'(FRAG_BYTES - 32);
  localparam logic [LW-1:0] CAP_L = LW'(FRAG_BYTES - 32);
  localparam logic [CW-1:0] LAST_FRAG = CW'(NUM_FRAGS - 1);
  localparam logic [CW:0]   FRAG_CNT  = (CW + 1)'(NUM_FRAGS);

  function automatic logic frag_ok(input logic [FW-1:0] f);
    frag_ok = (f != '0) && (CW'(f) < CW'(NUM_FRAGS));
  endfunction

  // pool number reduced modulo the pool count, worked out at elaboration
  logic [PW-1:0] pool_map [NUM_IDS];
  for (genvar k = 0; k < NUM_IDS; k++) begin : g_pool_map
    assign pool_map[k] = PW'(k % NUM_POOLS);
  end

  logic [FW-1:0] link_mem [NUM_FRAGS];
  logic [BW-1:0] room_mem [NUM_FRAGS];

  logic [FW-1:0] pool_cur_q [NUM_POOLS];
  logic [FW-1:0] free_head_q;
  logic [CW-1:0] fill_q;
  logic [CW-1:0] count_q;
  logic [FW-1:0] cur_q;
  logic [PW-1:0] pool_q;
  logic [LW-1:0] len_q;
  logic          str_q;
  pfa_pkg::status_e res_status_q;

  logic [FW-1:0] nl_addr_q, bfa_addr_q, bfb_addr_q;
  logic [FW-1:0] nl_rd_q;
  logic [BW-1:0] bfa_rd_q, bfb_rd_q;

  logic          rsp_valid_q;
  pfa_pkg::rsp_t rsp_q;

  // request decode
  pfa_pkg::mode_e in_mode;
  pfa_pkg::kind_e in_kind;
  logic [LW-1:0]  in_len;
  logic           in_too_big;

  // table view with untouched fragments at their reset value
  logic [FW-1:0] nl_val;
  logic [BW-1:0] bf_f, bf_nraw, bf_n, sel_bf, off_b, new_bf;
  logic [FW-1:0] f_cur, nf, sel_f, pool_f;
  logic          fits, nf_ok, pop, rsv_good;
  pfa_pkg::status_e rsv_status;

  logic          link_we, room_we, link_re;
  logic [FW-1:0] link_waddr, link_wdata, room_waddr, link_raddr;
  logic [BW-1:0] room_wdata;

  always_comb begin
    in_mode    = pfa_pkg::mode_e'(req_i.mode);
    in_len     = LW'(req_i.alloc_length);
    if (in_mode == pfa_pkg::MODE_BUF && req_i.alloc_length == '0) in_len = LW'(1);
    in_too_big = in_len >= CAP_L;
    case (in_mode)
      pfa_pkg::MODE_FREE: in_kind = pfa_pkg::KIND_FREE;
      pfa_pkg::MODE_NOP:  in_kind = pfa_pkg::KIND_DIRECT;
      default:            in_kind = in_too_big ? pfa_pkg::KIND_DIRECT : pfa_pkg::KIND_RSV;
    endcase
  end

  always_comb begin
    pool_f = pool_cur_q[pool_q];
    f_cur  = bfa_addr_q;
    nf     = bfb_addr_q;

    if (CW'(nl_addr_q) < fill_q) begin
      nl_val = nl_rd_q;
    end else if (CW'(nl_addr_q) == LAST_FRAG) begin
      nl_val = '0;
    end else begin
      nl_val = FW'(CW'(nl_addr_q) + CW'(1));
    end
    bf_f    = (CW'(f_cur) < fill_q) ? bfa_rd_q : '0;
    bf_nraw = (CW'(nf) < fill_q) ? bfb_rd_q : '0;

    fits = frag_ok(f_cur) &&
           (str_q ? ((len_q + LW'(2)) < LW'(bf_f)) : (len_q < LW'(bf_f)));
    nf_ok    = frag_ok(nf);
    pop      = !fits && nf_ok;
    rsv_good = fits || nf_ok;
    rsv_status = rsv_good ? pfa_pkg::STAT_OK : pfa_pkg::STAT_NOFRAG;

    bf_n   = (bf_nraw == '0) ? CAP_B : bf_nraw;
    sel_bf = fits ? bf_f : bf_n;
    sel_f  = fits ? f_cur : nf;
    off_b  = CAP_B - sel_bf;
    new_bf = BW'(LW'(sel_bf) - len_q - LW'(1));

    stat_o.kind      = in_kind;
    stat_o.walk_ok   = frag_ok(pool_f);
    stat_o.walk_more = frag_ok(nl_val) && ((CW + 1)'(count_q) + (CW + 1)'(1) < FRAG_CNT);
    stat_o.out_free  = !rsp_valid_q || rsp_ready_i;
  end

  // memory port steering
  always_comb begin
    link_re    = cmd_i.rsv_read || cmd_i.walk_start || cmd_i.walk_step;
    link_raddr = cmd_i.rsv_read ? free_head_q : (cmd_i.walk_start ? pool_f : nl_val);
    link_we    = (cmd_i.rsv_eval && pop) || cmd_i.walk_step;
    link_waddr = cmd_i.walk_step ? cur_q : nf;
    link_wdata = cmd_i.walk_step ? free_head_q : f_cur;
    room_we    = (cmd_i.rsv_eval && rsv_good) || cmd_i.walk_step;
    room_waddr = cmd_i.walk_step ? cur_q : sel_f;
    room_wdata = cmd_i.walk_step ? CAP_B : new_bf;
  end

  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    if (link_re) begin
      nl_rd_q   <= link_mem[link_raddr];
      nl_addr_q <= link_raddr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (room_we) room_mem[room_waddr] <= room_wdata;
    if (cmd_i.rsv_read) begin
      bfa_rd_q   <= room_mem[pool_f];
      bfa_addr_q <= pool_f;
      bfb_rd_q   <= room_mem[free_head_q];
      bfb_addr_q <= free_head_q;
    end
  end

  // request fields and walk cursor
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pool_q       <= pool_map[req_i.pool_id];
      len_q        <= in_len;
      str_q        <= (in_mode == pfa_pkg::MODE_STR);
      res_status_q <= (in_mode != pfa_pkg::MODE_NOP && in_mode != pfa_pkg::MODE_FREE &&
                       in_too_big) ? pfa_pkg::STAT_LEN : pfa_pkg::STAT_OK;
    end
    if (cmd_i.accept || cmd_i.walk_start) begin
      count_q <= '0;
    end else if (cmd_i.walk_step) begin
      count_q <= count_q + CW'(1);
    end
    if (cmd_i.walk_start) begin
      cur_q <= pool_f;
    end else if (cmd_i.walk_step) begin
      cur_q <= nl_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= FW'(1);
      fill_q      <= CW'(1);
      for (int p = 0; p < NUM_POOLS; p++) pool_cur_q[p] <= '0;
    end else begin
      if (cmd_i.walk_start) pool_cur_q[pool_q] <= '0;
      if (cmd_i.rsv_eval && pop) begin
        pool_cur_q[pool_q] <= nf;
        free_head_q        <= nl_val;
        if (CW'(nf) == fill_q) fill_q <= fill_q + CW'(1);
      end
      if (cmd_i.walk_step) free_head_q <= cur_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.rsv_eval || cmd_i.fin_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rsv_eval) begin
      rsp_q.status         <= rsv_status;
      rsp_q.frag_index     <= rsv_good ? pfa_pkg::IDX_W'(sel_f) : '0;
      rsp_q.byte_offset    <= rsv_good ? pfa_pkg::OFF_W'(off_b) : '0;
      rsp_q.frags_released <= '0;
    end else if (cmd_i.fin_load) begin
      rsp_q.status         <= res_status_q;
      rsp_q.frag_index     <= '0;
      rsp_q.byte_offset    <= '0;
      rsp_q.frags_released <= pfa_pkg::IDX_W'(count_q);
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != '0 && CW'(fill_q) <= CW'(NUM_FRAGS))
    else $error("fill count out of range");

  a_fill_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q >= $past(fill_q))
    else $error("fill count went down");

  a_walk_frag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_step |-> frag_ok(cur_q))
    else $error("walk released an invalid fragment");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rsv_eval || cmd_i.fin_load) |=> rsp_valid_q)
    else $error("result not presented after completion");

endmodule

// ===== hw/rtl/pooled_fragment_allocator.sv =====
// reservation: request accepted in idle, tables read in the next cycle, result registered in evaluate once free
// requests do not overlap: the next request is taken only once the sequencer is back in idle
// free pool: walks the chain from the pool head, one link read per released fragment
// the result register lets a waiting result hold while the next request is taken in
// reset: asynchronous, active low; free list, pool heads and fill count return at once
// tables need no clearing pass: a fill count marks fragments that still hold reset values
module pooled_fragment_allocator #(
  parameter int unsigned NUM_FRAGS  = pfa_pkg::NUM_FRAGS_DEF,
  parameter int unsigned NUM_POOLS  = pfa_pkg::NUM_POOLS_DEF,
  parameter int unsigned FRAG_BYTES = pfa_pkg::FRAG_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pfa_req_if.sink    req_i,
  pfa_rsp_if.source  rsp_o
);

  // commands from the sequencer, status back from the datapath
  pfa_pkg::cmd_t  cmd;
  pfa_pkg::stat_t stat;

  // sequencer: idle, table read, evaluate and commit, walk the pool chain, or finish
  pfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: link table, room table, pool heads, free list head and result register
  pfa_dp #(
    .NUM_FRAGS  (NUM_FRAGS),
    .NUM_POOLS  (NUM_POOLS),
    .FRAG_BYTES (FRAG_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i.payload),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_o       (rsp_o.payload)
  );

endmodule
